FILE: design/assert_macros.svh
// Assertion macros for the checker module of this project.
// Each macro expects a signal named clk in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge, including during reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/ohrb_pkg.sv
// Package for the overwriting history ring buffer: depth, widths, mode codes
// and the control struct between the pointer logic and the word store.
`timescale 1ns / 1ps

package ohrb_pkg;

  localparam int DEPTH = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = 32;
  localparam int IDX_W = 16;
  localparam int MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              clr;
    logic [ADDR_W-1:0] rd_addr_old;
    logic [ADDR_W-1:0] rd_addr_idx;
  } store_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic idx_ok;
  } ring_status_t;

endpackage

FILE: design/ohrb_ctrl.sv
// Pointer and flag logic of the history ring: advances the newest and oldest
// slots per request and drives the store's write and read addresses. Uses ohrb_pkg.
`timescale 1ns / 1ps

module ohrb_ctrl import ohrb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [MODE_W-1:0]  mode,
  input  logic [IDX_W-1:0]   index,
  output store_ctrl_t        ctrl,
  output ring_status_t       status
);

  logic [ADDR_W-1:0] newest_r, newest_nxt;
  logic [ADDR_W-1:0] oldest_r, oldest_nxt;
  logic              empty_r, empty_nxt;
  logic              full_r, full_nxt;
  logic              idx_ok_r, idx_ok_nxt;
  logic [ADDR_W:0]   idx_sum;

  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p);
    advance = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    newest_nxt   = newest_r;
    oldest_nxt   = oldest_r;
    empty_nxt    = empty_r;
    full_nxt     = full_r;
    ctrl.wr_en   = 1'b0;
    ctrl.wr_addr = newest_r;
    ctrl.clr     = 1'b0;
    if (accept) begin
      case (mode_t'(mode))
        MODE_PUSH: begin
          ctrl.wr_en = 1'b1;
          if (full_r) begin
            newest_nxt = advance(newest_r);
            oldest_nxt = advance(oldest_r);
          end else if (!empty_r) begin
            newest_nxt = advance(newest_r);
            if (newest_nxt == ADDR_W'(DEPTH - 1)) begin
              full_nxt = 1'b1;
            end
          end
          empty_nxt    = 1'b0;
          ctrl.wr_addr = newest_nxt;
        end
        MODE_CLEAR: begin
          ctrl.clr   = 1'b1;
          newest_nxt = '0;
          oldest_nxt = '0;
          empty_nxt  = 1'b1;
          full_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
    idx_sum          = {1'b0, oldest_nxt} + {1'b0, index[ADDR_W-1:0]};
    ctrl.rd_addr_old = oldest_nxt;
    if (idx_sum >= (ADDR_W + 1)'(DEPTH)) begin
      ctrl.rd_addr_idx = ADDR_W'(idx_sum - (ADDR_W + 1)'(DEPTH));
    end else begin
      ctrl.rd_addr_idx = idx_sum[ADDR_W-1:0];
    end
  end

  assign idx_ok_nxt = (index < IDX_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      oldest_r <= '0;
      empty_r  <= 1'b1;
      full_r   <= 1'b0;
      idx_ok_r <= 1'b0;
    end else begin
      newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
      empty_r  <= empty_nxt;
      full_r   <= full_nxt;
      if (accept) begin
        idx_ok_r <= idx_ok_nxt;
      end
    end
  end

  assign status.empty  = empty_r;
  assign status.full   = full_r;
  assign status.idx_ok = idx_ok_r;

endmodule

FILE: design/ohrb_store.sv
// Word store of the history ring: one write port, two registered read ports
// with write forwarding, per-slot valid bits and a newest-word copy. Uses ohrb_pkg.
`timescale 1ns / 1ps

module ohrb_store import ohrb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  store_ctrl_t       ctrl,
  input  logic [WORD_W-1:0] wr_data,
  output logic [WORD_W-1:0] old_data,
  output logic [WORD_W-1:0] idx_data,
  output logic [WORD_W-1:0] new_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [WORD_W-1:0] old_data_r;
  logic [WORD_W-1:0] idx_data_r;
  logic [WORD_W-1:0] new_data_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      vld_r <= '0;
    end else if (ctrl.wr_en) begin
      vld_r[ctrl.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (ctrl.wr_en && (ctrl.rd_addr_old == ctrl.wr_addr)) begin
        old_data_r <= wr_data;
      end else if (vld_r[ctrl.rd_addr_old] && !ctrl.clr) begin
        old_data_r <= mem[ctrl.rd_addr_old];
      end else begin
        old_data_r <= '0;
      end
      if (ctrl.wr_en && (ctrl.rd_addr_idx == ctrl.wr_addr)) begin
        idx_data_r <= wr_data;
      end else if (vld_r[ctrl.rd_addr_idx] && !ctrl.clr) begin
        idx_data_r <= mem[ctrl.rd_addr_idx];
      end else begin
        idx_data_r <= '0;
      end
    end
    if (ctrl.wr_en) begin
      new_data_r <= wr_data;
    end
  end

  assign old_data = old_data_r;
  assign idx_data = idx_data_r;
  assign new_data = new_data_r;

endmodule

FILE: design/overwriting_history_ring_buffer.sv
// Top level of the overwriting history ring buffer: stream ports, result
// register handshake, and the ohrb_ctrl and ohrb_store instances. Uses ohrb_pkg.
//
//   Channel   Direction   Payload (tdata, lowest bit first)
//   in_       request     mode[1:0], value[33:2], index[49:34], zero fill to 56
//   out_      result      read_value, newest_value, oldest_value, is_empty,
//                         is_full, zero fill to 104
//
// The result register is the only stage and holds each result from the cycle after
// acceptance. A request can be accepted every cycle unless the result is stalled.
// While a result waits unread, the next request is taken once it is read.
// Reset empties the ring and clears all slots; no fill pass is needed.
`timescale 1ns / 1ps

module overwriting_history_ring_buffer import ohrb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // mode[1:0], value[33:2], index[49:34]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // read_value, newest_value, oldest_value,
                                   // is_empty, is_full
);

  logic              accept;
  logic              out_valid_r;
  store_ctrl_t       ctrl;
  ring_status_t      status;
  logic [WORD_W-1:0] old_data;
  logic [WORD_W-1:0] idx_data;
  logic [WORD_W-1:0] new_data;
  logic [WORD_W-1:0] read_value;
  logic [WORD_W-1:0] newest_value;
  logic [WORD_W-1:0] oldest_value;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  ohrb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .mode   (in_tdata[1:0]),
    .index  (in_tdata[49:34]),
    .ctrl   (ctrl),
    .status (status)
  );

  ohrb_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .ctrl     (ctrl),
    .wr_data  (in_tdata[33:2]),
    .old_data (old_data),
    .idx_data (idx_data),
    .new_data (new_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign read_value   = (!status.empty && status.idx_ok) ? idx_data : '0;
  assign newest_value = status.empty ? '0 : new_data;
  assign oldest_value = status.empty ? '0 : old_data;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, status.full, status.empty, oldest_value, newest_value,
                       read_value};

endmodule

FILE: design/ohrb_checker.sv
// Port checker for the overwriting history ring buffer, bound to the top level.
// Uses the macros of assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ohrb_checker import ohrb_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [55:0]  in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  logic clear_fire;
  logic out_empty;
  logic out_full;

  assign clear_fire = in_tvalid && in_tready && (in_tdata[1:0] == MODE_CLEAR);
  assign out_empty  = out_tdata[96];
  assign out_full   = out_tdata[97];

  `ASSERT_ALWAYS(a_reset_clears_valid, !rst_n |=> !out_tvalid)
  `ASSERT_IMPL(a_not_empty_and_full, out_tvalid, !(out_empty && out_full))
  `ASSERT_IMPL(a_empty_reads_zero, out_tvalid && out_empty, out_tdata[95:0] == 96'd0)
  `ASSERT_NEXT(a_clear_gives_empty, clear_fire, out_tvalid && out_empty && !out_full)
  `ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind overwriting_history_ring_buffer ohrb_checker u_ohrb_checker (.*);
